[rtl/core/colt_pkg.sv]
package colt_pkg;

   localparam int BYTE_W = 8;
   localparam int NCOL_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLUMNS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_BYTE     = 2'd2;

   localparam logic [NCOL_W-1:0] NUM_COLUMNS_RST = 5'd4;
   localparam logic [BYTE_W-1:0] PAD_BYTE_RST    = 8'd88;

   typedef enum logic [3:0] {
      ST_CAP  = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

[rtl/core/columnar_transposition.sv]
// Columnar transposition of a byte message, encrypt or decrypt.
// Request channel (req_*): one message byte per accepted request, the last
// byte flagged by req_end_of_message. While req_stall is low, bytes load at
// one per cycle into a single-port message memory. Bytes past the largest
// whole-row capacity are dropped and the run is flagged truncated.
// After the last byte the block sizes the grid to ceil(n / columns) rows by
// repeated addition of the column count, then reads the memory at one
// address per cycle while the output is not stalled; each read lands in
// the output register, so results follow at one per cycle. A run has
// rows * columns results.
// req_stall is high while sizing and emitting, and while the capacity is
// computed by repeated addition after reset or after a write of num_columns.
// A stall on rsp_stall holds the output register and pauses the memory
// reads; a new message is taken as soon as the final read has been issued.
// Reset (synchronous) restores the register defaults, empties the buffer and
// starts the capacity pass. Configuration (csr_*) is for the user to write
// only while idle; the block itself does not enforce it.
module columnar_transposition
   import colt_pkg::*;
#(
   parameter int BUF_DEPTH   = 64,
   parameter int MAX_COLUMNS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_end_of_message,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [BYTE_W-1:0]    rsp_out_byte,
   output logic                 rsp_last_of_run,
   output logic                 rsp_truncated,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   localparam int MAX_EFF = (MAX_COLUMNS < BUF_DEPTH) ? MAX_COLUMNS : BUF_DEPTH;
   localparam int CW      = $clog2(MAX_EFF + 1);
   localparam int AW      = $clog2(BUF_DEPTH);
   localparam int CNTW    = $clog2(BUF_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [NCOL_W-1:0] num_columns_ff, num_columns_in;
   logic              decrypt_mode_ff, decrypt_mode_in;
   logic [BYTE_W-1:0] pad_byte_ff, pad_byte_in;
   logic [CNTW-1:0]   cap_ff, cap_in;
   logic [CNTW-1:0]   byte_count_ff, byte_count_in;
   logic              overflow_ff, overflow_in;
   logic [CNTW-1:0]   n_ff, n_in;
   logic              trunc_ff, trunc_in;
   logic [CNTW-1:0]   rows_ff, rows_in;
   logic [CNTW:0]     acc_ff, acc_in;
   logic [CNTW:0]     src_ff, src_in;
   logic [CNTW-1:0]   inner_ff, inner_in;
   logic [CNTW-1:0]   outer_ff, outer_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] mem_q_ff;
   logic              pad_sel_ff;
   logic              rsp_last_ff;
   logic              rsp_trunc_ff;

   logic [CW-1:0]     cols_eff;
   logic [CNTW:0]     cap_sum;
   logic              req_take;
   logic              room;
   logic [CNTW-1:0]   count_nx;
   logic              ovf_nx;
   logic              issue;
   logic [CNTW:0]     stride;
   logic [CNTW-1:0]   ilim, olim;
   logic              inner_last, outer_last;

   // column count clamped to 1 .. min(MAX_COLUMNS, BUF_DEPTH)
   always_comb begin
      if (num_columns_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(num_columns_ff) > 32'(MAX_EFF)) begin
         cols_eff = CW'(MAX_EFF);
      end else begin
         cols_eff = CW'(num_columns_ff);
      end
   end

   assign req_stall  = (state_ff != ST_LOAD);
   assign req_take   = req_valid && (state_ff == ST_LOAD);
   assign cap_sum    = (CNTW+1)'(cap_ff) + (CNTW+1)'(cols_eff);
   assign room       = (byte_count_ff < cap_ff);
   assign count_nx   = room ? byte_count_ff + CNTW'(1) : byte_count_ff;
   assign ovf_nx     = overflow_ff || !room;

   // encrypt walks columns outer, rows inner; decrypt the other way round
   assign stride     = decrypt_mode_ff ? (CNTW+1)'(rows_ff) : (CNTW+1)'(cols_eff);
   assign ilim       = decrypt_mode_ff ? CNTW'(cols_eff) : rows_ff;
   assign olim       = decrypt_mode_ff ? rows_ff : CNTW'(cols_eff);
   assign inner_last = (inner_ff == ilim - CNTW'(1));
   assign outer_last = (outer_ff == olim - CNTW'(1));
   assign issue      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      num_columns_in  = num_columns_ff;
      decrypt_mode_in = decrypt_mode_ff;
      pad_byte_in     = pad_byte_ff;
      cap_in          = cap_ff;
      byte_count_in   = byte_count_ff;
      overflow_in     = overflow_ff;
      n_in            = n_ff;
      trunc_in        = trunc_ff;
      rows_in         = rows_ff;
      acc_in          = acc_ff;
      src_in          = src_ff;
      inner_in        = inner_ff;
      outer_in        = outer_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_CAP: begin
            if (cap_sum <= (CNTW+1)'(BUF_DEPTH)) begin
               cap_in = cap_sum[CNTW-1:0];
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (req_take) begin
               if (req_end_of_message) begin
                  // held count clamped to capacity if columns changed mid message
                  if (count_nx > cap_ff) begin
                     n_in     = cap_ff;
                     trunc_in = 1'b1;
                  end else begin
                     n_in     = count_nx;
                     trunc_in = ovf_nx;
                  end
                  byte_count_in = '0;
                  overflow_in   = 1'b0;
                  rows_in       = '0;
                  acc_in        = '0;
                  state_in      = ST_SIZE;
               end else begin
                  byte_count_in = count_nx;
                  overflow_in   = ovf_nx;
               end
            end
         end
         ST_SIZE: begin
            if (acc_ff < (CNTW+1)'(n_ff)) begin
               acc_in  = acc_ff + (CNTW+1)'(cols_eff);
               rows_in = rows_ff + CNTW'(1);
            end else begin
               src_in   = '0;
               inner_in = '0;
               outer_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               rsp_valid_in = 1'b1;
               if (inner_last) begin
                  inner_in = '0;
                  if (outer_last) begin
                     state_in = ST_LOAD;
                  end else begin
                     outer_in = outer_ff + CNTW'(1);
                     src_in   = (CNTW+1)'(outer_ff) + (CNTW+1)'(1);
                  end
               end else begin
                  inner_in = inner_ff + CNTW'(1);
                  src_in   = src_ff + stride;
               end
            end
         end
         default: begin
            state_in = ST_CAP;
            cap_in   = '0;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_NUM_COLUMNS: begin
               num_columns_in = csr_wdata[NCOL_W-1:0];
               // capacity follows the new column count
               cap_in         = '0;
               state_in       = ST_CAP;
            end
            CSR_DECRYPT_MODE: decrypt_mode_in = csr_wdata[0];
            CSR_PAD_BYTE:     pad_byte_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CAP;
         num_columns_ff  <= NUM_COLUMNS_RST;
         decrypt_mode_ff <= 1'b0;
         pad_byte_ff     <= PAD_BYTE_RST;
         cap_ff          <= '0;
         byte_count_ff   <= '0;
         overflow_ff     <= 1'b0;
         n_ff            <= '0;
         trunc_ff        <= 1'b0;
         rows_ff         <= '0;
         acc_ff          <= '0;
         src_ff          <= '0;
         inner_ff        <= '0;
         outer_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         num_columns_ff  <= num_columns_in;
         decrypt_mode_ff <= decrypt_mode_in;
         pad_byte_ff     <= pad_byte_in;
         cap_ff          <= cap_in;
         byte_count_ff   <= byte_count_in;
         overflow_ff     <= overflow_in;
         n_ff            <= n_in;
         trunc_ff        <= trunc_in;
         rows_ff         <= rows_in;
         acc_ff          <= acc_in;
         src_ff          <= src_in;
         inner_ff        <= inner_in;
         outer_ff        <= outer_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // message memory: writes only while loading, reads only while emitting
   always_ff @(posedge clock) begin
      if (req_take && room) begin
         mem[byte_count_ff[AW-1:0]] <= req_in_byte;
      end
      if (issue) begin
         mem_q_ff <= mem[src_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         pad_sel_ff   <= (src_ff >= (CNTW+1)'(n_ff));
         rsp_last_ff  <= inner_last && outer_last;
         rsp_trunc_ff <= trunc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = pad_sel_ff ? pad_byte_ff : mem_q_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_truncated   = rsp_trunc_ff;

   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result appeared outside emission");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (byte_count_ff <= CNTW'(BUF_DEPTH)) && (cap_ff <= CNTW'(BUF_DEPTH)))
      else $error("byte count or capacity beyond buffer depth");

   a_last_ends_run : assert property (@(posedge clock) disable iff (reset)
      issue && inner_last && outer_last && !csr_write |=> state_ff == ST_LOAD)
      else $error("final read did not return to loading");

endmodule

[tb/colt_checker.sv]
`timescale 1ns / 1ps

// watches request, response and csr traffic, predicts every transposed byte
// and compares each accepted response with the oldest prediction
module colt_checker
   import colt_pkg::*;
#(
   parameter int BUF_DEPTH   = 64,
   parameter int MAX_COLUMNS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   input  logic                 req_end_of_message,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [BYTE_W-1:0]    rsp_out_byte,
   input  logic                 rsp_last_of_run,
   input  logic                 rsp_truncated,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending
);

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              trunc;
   } cipher_byte_t;

   cipher_byte_t      cipher_queue[$];

   // shadow copy of the block's registers and message buffer
   logic [NCOL_W-1:0] grid_columns;
   logic              decrypting;
   logic [BYTE_W-1:0] fill_byte;
   logic [BYTE_W-1:0] msg_store[BUF_DEPTH];
   int                held;
   logic              dropped;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic note_mismatch(input string what, input cipher_byte_t want,
                                input cipher_byte_t got);
      if (fail_count < 10) begin
         $display("%0t mismatch (%s): expected byte %02h last %b trunc %b, got byte %02h last %b trunc %b",
                  $realtime, what, want.data, want.last, want.trunc,
                  got.data, got.last, got.trunc);
      end
      fail_count = fail_count + 1;
   endtask

   always @(posedge clock) begin
      int           cols, cap, n, rows, total, src;
      cipher_byte_t want, got;
      if (reset) begin
         grid_columns = NUM_COLUMNS_RST;
         decrypting   = 1'b0;
         fill_byte    = PAD_BYTE_RST;
         held         = 0;
         dropped      = 1'b0;
         cipher_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_last_of_run, rsp_truncated};
            if (cipher_queue.size() == 0) begin
               note_mismatch("unexpected response", '0, got);
            end else begin
               want = cipher_queue.pop_front();
               if (got !== want) note_mismatch("response", want, got);
            end
         end

         if (req_valid && !req_stall) begin
            cols = (grid_columns == 0) ? 1 : int'(grid_columns);
            if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
            if (cols > BUF_DEPTH) cols = BUF_DEPTH;
            cap = (BUF_DEPTH / cols) * cols;
            if (held < cap && held < BUF_DEPTH) begin
               msg_store[held] = req_in_byte;
               held = held + 1;
            end else begin
               dropped = 1'b1;
            end
            if (req_end_of_message) begin
               n = held;
               // column count shrank while bytes were held
               if (n > cap) begin
                  n = cap;
                  dropped = 1'b1;
               end
               rows  = (n + cols - 1) / cols;
               total = rows * cols;
               for (int k = 0; k < total; k++) begin
                  if (decrypting) src = (k % cols) * rows + k / cols;
                  else src = (k % rows) * cols + k / rows;
                  want.data  = (src < n) ? msg_store[src] : fill_byte;
                  want.last  = (k == total - 1);
                  want.trunc = dropped;
                  cipher_queue.push_back(want);
               end
               held    = 0;
               dropped = 1'b0;
            end
         end

         if (csr_write) begin
            case (csr_index)
               CSR_NUM_COLUMNS: begin
                  grid_columns = csr_wdata[NCOL_W-1:0];
               end
               CSR_DECRYPT_MODE: begin
                  decrypting = csr_wdata[0];
               end
               CSR_PAD_BYTE: begin
                  fill_byte = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      pending <= cipher_queue.size();
   end

endmodule

[tb/tb_columnar_transposition.sv]
`timescale 1ns / 1ps

module tb_columnar_transposition;
   import colt_pkg::*;

   localparam int BUF_DEPTH   = 64;
   localparam int MAX_COLUMNS = 16;
   localparam int RANDOM_REQS = 350;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 req_end_of_message = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_last_of_run;
   logic                 rsp_truncated;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_wdata = '0;

   int                   fail_count;
   int                   pending;
   int                   reqs_sent = 0;
   logic                 quiet = 1'b0;

   columnar_transposition #(
      .BUF_DEPTH  (BUF_DEPTH),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_truncated     (rsp_truncated),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   colt_checker #(
      .BUF_DEPTH  (BUF_DEPTH),
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_message(req_end_of_message),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_truncated     (rsp_truncated),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 21);
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // one request; valid stays high afterwards so back-to-back requests need no gap
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eom);
      if (!quiet && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_in_byte        <= b;
      req_end_of_message <= eom;
      do @(posedge clock); while (req_stall);
      reqs_sent = reqs_sent + 1;
   endtask

   task automatic send_message(input int len, input logic finish_it);
      for (int i = 0; i < len; i++) begin
         send_byte(BYTE_W'($urandom), finish_it && (i == len - 1));
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // sender holds off until every predicted byte has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic pick_columns(output logic [BYTE_W-1:0] data);
      logic [NCOL_W-1:0] c;
      case ($urandom_range(9))
         0: c = 5'd0;
         1: c = 5'd1;
         2: c = 5'd16;
         3: c = NCOL_W'($urandom_range(17, 31));
         default: c = NCOL_W'($urandom_range(1, 16));
      endcase
      data = {3'($urandom), c};
   endtask

   initial begin
      logic [BYTE_W-1:0] d;
      int                phase;
      int                len;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: four columns, encrypt, pad X
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'hFF, 1'b1);

      // zero columns act as one
      settle();
      write_csr(CSR_NUM_COLUMNS, 8'h00);
      write_csr(CSR_DECRYPT_MODE, 8'h01);
      write_csr(CSR_PAD_BYTE, 8'h00);
      send_byte(8'h12, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);

      // column count above the maximum saturates
      settle();
      write_csr(CSR_NUM_COLUMNS, 8'h1F);
      write_csr(CSR_DECRYPT_MODE, 8'h00);
      write_csr(CSR_PAD_BYTE, 8'hFF);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);

      settle();
      write_csr(CSR_NUM_COLUMNS, 8'h03);
      write_csr(CSR_DECRYPT_MODE, 8'h01);
      send_message(7, 1'b1);

      // column count changed while a message is held
      settle();
      write_csr(CSR_NUM_COLUMNS, 8'h05);
      send_message(3, 1'b0);
      req_valid <= 1'b0;
      repeat (10) @(posedge clock);
      write_csr(CSR_NUM_COLUMNS, 8'h02);
      send_byte(8'hC3, 1'b1);

      settle();
      write_csr(CSR_UNUSED, 8'($urandom));

      phase = 0;
      reqs_sent = 0;
      while (reqs_sent < RANDOM_REQS) begin
         settle();
         quiet = (phase % 5 == 2);
         pick_columns(d);
         write_csr(CSR_NUM_COLUMNS, d);
         write_csr(CSR_DECRYPT_MODE, 8'($urandom));
         case ($urandom_range(3))
            0: d = 8'h00;
            1: d = 8'hFF;
            default: d = 8'($urandom);
         endcase
         write_csr(CSR_PAD_BYTE, d);

         if ($urandom_range(2) == 0) begin
            // partial message, new column count, then the rest
            send_message($urandom_range(1, 64), 1'b0);
            req_valid <= 1'b0;
            repeat (10) @(posedge clock);
            pick_columns(d);
            write_csr(CSR_NUM_COLUMNS, d);
            send_message($urandom_range(1, 10), 1'b1);
         end

         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(99) < 15) len = $urandom_range(48, 70);
            else len = $urandom_range(1, 20);
            send_message(len, 1'b1);
         end
         phase = phase + 1;
      end

      quiet = 1'b0;
      settle();
      repeat (80) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[columnar_transposition.f]
rtl/core/colt_pkg.sv
rtl/core/columnar_transposition.sv
tb/colt_checker.sv
tb/tb_columnar_transposition.sv
